### rtl/core/rtcdc_pkg.sv
// ----------------------------------------------------------------------------
// rtcdc_pkg
// Shared types and constants for the RTC drift compensator.
// ----------------------------------------------------------------------------
package rtcdc_pkg;

    localparam int DEF_TIME_BITS  = 32;
    localparam int DEF_DRIFT_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int INTERVAL_BITS  = 32;
    localparam int THRESH_BITS    = 16;

    localparam int INTERVAL_RESET = 24 * 60 * 60;
    localparam int THRESH_RESET   = 100;

    localparam int TRIM_BITS  = 7;
    localparam int TRIM_SCALE = 1048576;
    localparam int TRIM_MAX   = 127;
    localparam int TRIM_LIMIT = TRIM_SCALE / TRIM_MAX;
    localparam int SCALE_BITS = 21;

    localparam int STATUS_BITS = 3;

    typedef enum logic [1:0] {
        MODE_SYNC      = 2'd0,
        MODE_CALIBRATE = 2'd1,
        MODE_ADJUST    = 2'd2,
        MODE_CLEAR     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE        = 3'd0,
        ST_TOO_SOON    = 3'd1,
        ST_NOT_CAL     = 3'd2,
        ST_ALREADY_CAL = 3'd3,
        ST_ZERO_DRIFT  = 3'd4
    } t_status;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_GRAN_THRESH  = 2'd1
    } t_cfg_reg;

endpackage

### rtl/core/rtcdc_divider.sv
// ----------------------------------------------------------------------------
// rtcdc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtcdc_divider #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [WIDTH-1:0]    r_rem;
    logic [WIDTH-1:0]    r_quo;
    logic [WIDTH-1:0]    r_divisor;

    logic [WIDTH:0]      w_shift;
    logic [WIDTH:0]      w_trial;
    logic                w_fit;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_divisor};
    assign w_fit   = ~w_trial[WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_BITS'(WIDTH);
                r_rem     <= '0;
                r_quo     <= i_dividend;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? w_trial[WIDTH-1:0] : w_shift[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/rtc_drift_compensator.sv
// ----------------------------------------------------------------------------
// rtc_drift_compensator
// Sync, calibrate, adjust and clear events for an RTC with drift tracking.
// ----------------------------------------------------------------------------
// Steps: each event passes DIFF and EVAL; calibrate and adjust with a division
// then run the shared radix-2 divider in DIV and go on to APPLY, and a calibration
// that programs the trim divides again in TRIM; every event ends in OUT.
// Throughput: one event at a time; o_stall stays high until OUT is left.
// Reset (synchronous, active low) clears the adjust time, drift and trim and
// loads the configuration defaults; no clearing pass.
module rtc_drift_compensator #(
    parameter int TIME_BITS  = rtcdc_pkg::DEF_TIME_BITS,
    parameter int DRIFT_BITS = rtcdc_pkg::DEF_DRIFT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_mode,
    input  logic [TIME_BITS-1:0]                 i_rtc_now,
    input  logic [TIME_BITS-1:0]                 i_reference_time,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_set_rtc,
    output logic [TIME_BITS-1:0]                 o_new_rtc_time,
    output logic [rtcdc_pkg::STATUS_BITS-1:0]    o_status,
    output logic                                 o_low_granularity,
    output logic [rtcdc_pkg::TRIM_BITS-1:0]      o_trim_value,
    output logic signed [DRIFT_BITS-1:0]         o_drift_report,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rtcdc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rtcdc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int MAX_TD   = (TIME_BITS > DRIFT_BITS) ? TIME_BITS : DRIFT_BITS;
    localparam int DIV_BITS = (MAX_TD > rtcdc_pkg::SCALE_BITS) ? MAX_TD
                                                               : rtcdc_pkg::SCALE_BITS;
    localparam int CW       = MAX_TD + 2;
    localparam int LW       = (TIME_BITS > rtcdc_pkg::THRESH_BITS) ? TIME_BITS
                                                                   : rtcdc_pkg::THRESH_BITS + 1;
    localparam int CMPW     = (TIME_BITS > rtcdc_pkg::INTERVAL_BITS) ? TIME_BITS
                                                                     : rtcdc_pkg::INTERVAL_BITS;

    localparam longint DRIFT_MAX_L = (longint'(1) << (DRIFT_BITS - 1)) - 1;
    localparam longint DRIFT_MIN_L = -DRIFT_MAX_L - 1;
    localparam longint UPPER_L     = (DRIFT_MAX_L < rtcdc_pkg::TRIM_LIMIT) ? DRIFT_MAX_L
                                                                          : rtcdc_pkg::TRIM_LIMIT;
    localparam logic signed [CW-1:0] C_UPPER = CW'(UPPER_L);
    localparam logic signed [CW-1:0] C_DMIN  = CW'(DRIFT_MIN_L);
    localparam logic signed [CW-1:0] C_LIMIT = CW'(rtcdc_pkg::TRIM_LIMIT);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIFF  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_APPLY = 7'b0010000,
        S_TRIM  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                                  r_state;
    t_state                                  n_state;

    rtcdc_pkg::t_mode                        r_mode;
    logic [TIME_BITS-1:0]                    r_now;
    logic [TIME_BITS-1:0]                    r_ref;
    logic [TIME_BITS-1:0]                    r_d0;
    logic [TIME_BITS-1:0]                    r_d1;
    logic                                    r_neg;
    logic [TIME_BITS-1:0]                    r_q;

    logic [TIME_BITS-1:0]                    r_last;
    logic [DRIFT_BITS-1:0]                   r_drift;
    logic [rtcdc_pkg::TRIM_BITS-1:0]         r_trim;

    logic [rtcdc_pkg::INTERVAL_BITS-1:0]     r_min_int;
    logic [rtcdc_pkg::THRESH_BITS-1:0]       r_thr;

    logic                                    r_set;
    logic [TIME_BITS-1:0]                    r_newt;
    rtcdc_pkg::t_status                      r_status;
    logic                                    r_lowg;

    // divider hookup
    logic                                    w_div_start;
    logic [DIV_BITS-1:0]                     w_dividend;
    logic [DIV_BITS-1:0]                     w_divisor;
    logic                                    w_div_done;
    logic [DIV_BITS-1:0]                     w_div_quo;

    logic signed [DIV_BITS-1:0]              w_d0_s;
    logic signed [DIV_BITS-1:0]              w_d1_s;
    logic signed [DIV_BITS-1:0]              w_drift_s;
    logic [DIV_BITS-1:0]                     w_d0_abs;
    logic [DIV_BITS-1:0]                     w_d1_abs;
    logic [DIV_BITS-1:0]                     w_drift_abs;
    logic [DIV_BITS-1:0]                     w_q_signed;

    logic signed [LW-1:0]                    w_drift_cmp;
    logic signed [LW-1:0]                    w_thr_cmp;
    logic                                    w_lowg;
    logic                                    w_too_soon;
    logic                                    w_drift_zero;
    logic signed [CW-1:0]                    w_qx;
    logic                                    w_q_trim;
    logic                                    w_q_fits;

    assign w_d0_s      = DIV_BITS'($signed(r_d0));
    assign w_d1_s      = DIV_BITS'($signed(r_d1));
    assign w_drift_s   = DIV_BITS'($signed(r_drift));
    assign w_d0_abs    = w_d0_s[DIV_BITS-1]    ? DIV_BITS'(-w_d0_s)    : DIV_BITS'(w_d0_s);
    assign w_d1_abs    = w_d1_s[DIV_BITS-1]    ? DIV_BITS'(-w_d1_s)    : DIV_BITS'(w_d1_s);
    assign w_drift_abs = w_drift_s[DIV_BITS-1] ? DIV_BITS'(-w_drift_s) : DIV_BITS'(w_drift_s);
    assign w_q_signed  = r_neg ? DIV_BITS'(-w_div_quo) : w_div_quo;

    assign w_drift_cmp  = LW'($signed(r_d0));
    assign w_thr_cmp    = $signed(LW'(r_thr));
    assign w_lowg       = w_drift_cmp < w_thr_cmp;
    assign w_too_soon   = r_d0[TIME_BITS-1] || (CMPW'(r_d0) < CMPW'(r_min_int));
    assign w_drift_zero = (r_drift == '0);

    assign w_qx     = CW'($signed(r_q));
    assign w_q_trim = w_qx > C_LIMIT;
    assign w_q_fits = (w_qx > C_DMIN) && (w_qx <= C_UPPER);

    // divider operand select: event division from EVAL, trim division from APPLY
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = w_d1_abs;
        w_divisor   = w_d0_abs;
        if (r_state == S_EVAL) begin
            if (r_mode == rtcdc_pkg::MODE_CALIBRATE) begin
                w_div_start = w_drift_zero && (r_d0 != '0);
            end else if (r_mode == rtcdc_pkg::MODE_ADJUST) begin
                w_div_start = !w_too_soon && !w_drift_zero;
                w_dividend  = w_d0_abs;
                w_divisor   = w_drift_abs;
            end
        end else if (r_state == S_APPLY) begin
            w_div_start = (r_mode == rtcdc_pkg::MODE_CALIBRATE) && w_q_trim;
            w_dividend  = DIV_BITS'(rtcdc_pkg::TRIM_SCALE);
            w_divisor   = DIV_BITS'(r_q);
        end
    end

    rtcdc_divider #(
        .WIDTH      (DIV_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DIFF;
            S_DIFF:  n_state = S_EVAL;
            S_EVAL:  n_state = w_div_start ? S_DIV : S_OUT;
            S_DIV:   if (w_div_done) n_state = S_APPLY;
            S_APPLY: n_state = w_div_start ? S_TRIM : S_OUT;
            S_TRIM:  if (w_div_done) n_state = S_OUT;
            S_OUT:   if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_int <= rtcdc_pkg::INTERVAL_BITS'(rtcdc_pkg::INTERVAL_RESET);
            r_thr     <= rtcdc_pkg::THRESH_BITS'(rtcdc_pkg::THRESH_RESET);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rtcdc_pkg::CFG_MIN_INTERVAL) begin
                r_min_int <= i_cfg_data[rtcdc_pkg::INTERVAL_BITS-1:0];
            end else if (i_cfg_index == rtcdc_pkg::CFG_GRAN_THRESH) begin
                r_thr <= i_cfg_data[rtcdc_pkg::THRESH_BITS-1:0];
            end
        end
    end

    // event state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_drift <= '0;
            r_trim  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= rtcdc_pkg::t_mode'(i_mode);
                        r_now  <= i_rtc_now;
                        r_ref  <= i_reference_time;
                    end
                end
                S_DIFF: begin
                    r_d0 <= r_now - ((r_mode == rtcdc_pkg::MODE_CALIBRATE) ? r_ref : r_last);
                    r_d1 <= r_ref - r_last;
                end
                S_EVAL: begin
                    r_set    <= 1'b0;
                    r_newt   <= '0;
                    r_status <= rtcdc_pkg::ST_DONE;
                    r_lowg   <= 1'b0;
                    unique case (r_mode)
                        rtcdc_pkg::MODE_SYNC: begin
                            r_set  <= 1'b1;
                            r_newt <= r_ref;
                            r_last <= r_ref;
                        end
                        rtcdc_pkg::MODE_CALIBRATE: begin
                            if (!w_drift_zero) begin
                                r_status <= rtcdc_pkg::ST_ALREADY_CAL;
                            end else begin
                                r_lowg <= w_lowg;
                                r_neg  <= r_d1[TIME_BITS-1] ^ r_d0[TIME_BITS-1];
                                if (r_d0 == '0) begin
                                    r_status <= rtcdc_pkg::ST_ZERO_DRIFT;
                                end
                            end
                        end
                        rtcdc_pkg::MODE_ADJUST: begin
                            r_neg <= r_drift[DRIFT_BITS-1];
                            if (w_too_soon) begin
                                r_status <= rtcdc_pkg::ST_TOO_SOON;
                            end else if (w_drift_zero) begin
                                r_status <= rtcdc_pkg::ST_NOT_CAL;
                            end
                        end
                        rtcdc_pkg::MODE_CLEAR: begin
                            r_drift <= '0;
                        end
                        default: begin
                            r_drift <= '0;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_q <= w_q_signed[TIME_BITS-1:0];
                    end
                end
                S_APPLY: begin
                    if (r_mode == rtcdc_pkg::MODE_ADJUST) begin
                        r_set  <= 1'b1;
                        r_newt <= r_now - r_q;
                        r_last <= r_now - r_q;
                    end else if (!w_q_trim) begin
                        // out-of-range quotients leave the drift cleared
                        r_drift <= w_q_fits ? DRIFT_BITS'(w_qx) : '0;
                    end
                end
                S_TRIM: begin
                    if (w_div_done) begin
                        r_trim  <= w_div_quo[rtcdc_pkg::TRIM_BITS-1:0];
                        r_drift <= '0;
                    end
                end
                S_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_set_rtc         = r_set;
    assign o_new_rtc_time    = r_newt;
    assign o_status          = r_status;
    assign o_low_granularity = r_lowg;
    assign o_trim_value      = r_trim;
    assign o_drift_report    = $signed(r_drift);
    assign o_cfg_ready       = 1'b1;

endmodule
